[rtl/ffrps_pkg.sv]
// ffrps_pkg: shared types and constants for the first-fit record page store
// depends on nothing; used by ffrps_page_table and the top level
package ffrps_pkg;

  // width of the signed free-space count kept per page
  localparam int unsigned FS_W = 18;

  // bytes reserved at the head of each page, and per record slot
  localparam int unsigned HEADER_BYTES  = 16;
  localparam int unsigned SLOT_OVERHEAD = 4;

  // reset value of the page size register
  localparam logic [15:0] PAGE_SIZE_RST = 16'd4096;

  // encodings of "none" on the result index ports
  localparam logic [4:0] PAGE_NONE = 5'h1F;
  localparam logic [5:0] SLOT_NONE = 6'h3F;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_SEARCH = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    RES_OK        = 2'd0,
    RES_NOT_FOUND = 2'd1,
    RES_FULL      = 2'd2
  } res_e;

endpackage

[rtl/ffrps_page_table.sv]
// ffrps_page_table: per-page free space memory and record counters
// one write port and one registered read port; uses ffrps_pkg
module ffrps_page_table #(
  parameter int unsigned MAX_PAGES      = 16,
  parameter int unsigned SLOTS_PER_PAGE = 32
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic [(MAX_PAGES > 1 ? $clog2(MAX_PAGES) : 1)-1:0] rd_addr_i,
  input  logic                                          we_i,
  input  logic [(MAX_PAGES > 1 ? $clog2(MAX_PAGES) : 1)-1:0] wr_addr_i,
  input  logic signed [ffrps_pkg::FS_W-1:0]             wr_free_i,
  input  logic [$clog2(SLOTS_PER_PAGE+1)-1:0]           wr_count_i,
  output logic signed [ffrps_pkg::FS_W-1:0]             rd_free_o,
  output logic [$clog2(SLOTS_PER_PAGE+1)-1:0]           rd_count_o
);

  localparam int unsigned RCW = $clog2(SLOTS_PER_PAGE + 1);

  // free space: written before it is ever read, so no reset
  logic signed [ffrps_pkg::FS_W-1:0] free_mem [MAX_PAGES];
  // record counts start at zero
  logic [RCW-1:0] count_q [MAX_PAGES];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      free_mem[wr_addr_i] <= wr_free_i;
    end
    rd_free_o <= free_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(MAX_PAGES); i++) begin
        count_q[i] <= '0;
      end
      rd_count_o <= '0;
    end else begin
      if (we_i) begin
        count_q[wr_addr_i] <= wr_count_i;
      end
      rd_count_o <= count_q[rd_addr_i];
    end
  end

endmodule

[rtl/ffrps_key_store.sv]
// ffrps_key_store: key memory, one row per page, and the slot match unit
// row read is registered; match covers the filled slots of the row
module ffrps_key_store #(
  parameter int unsigned MAX_PAGES      = 16,
  parameter int unsigned SLOTS_PER_PAGE = 32,
  parameter int unsigned KEY_BITS       = 32
) (
  input  logic                                                 clk_i,
  input  logic [(MAX_PAGES > 1 ? $clog2(MAX_PAGES) : 1)-1:0]   rd_page_i,
  input  logic                                                 we_i,
  input  logic [(MAX_PAGES > 1 ? $clog2(MAX_PAGES) : 1)-1:0]   wr_page_i,
  input  logic [(SLOTS_PER_PAGE > 1 ? $clog2(SLOTS_PER_PAGE) : 1)-1:0] wr_slot_i,
  input  logic [KEY_BITS-1:0]                                  wr_key_i,
  input  logic [KEY_BITS-1:0]                                  cmp_key_i,
  input  logic [$clog2(SLOTS_PER_PAGE+1)-1:0]                  fill_i,
  output logic                                                 hit_o,
  output logic [(SLOTS_PER_PAGE > 1 ? $clog2(SLOTS_PER_PAGE) : 1)-1:0] hit_slot_o
);

  localparam int unsigned SIW = SLOTS_PER_PAGE > 1 ? $clog2(SLOTS_PER_PAGE) : 1;
  localparam int unsigned RCW = $clog2(SLOTS_PER_PAGE + 1);

  logic [SLOTS_PER_PAGE-1:0][KEY_BITS-1:0] key_mem [MAX_PAGES];
  logic [SLOTS_PER_PAGE-1:0][KEY_BITS-1:0] row_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      key_mem[wr_page_i][wr_slot_i] <= wr_key_i;
    end
    row_q <= key_mem[rd_page_i];
  end

  // lowest filled slot that holds the key
  always_comb begin
    hit_o      = 1'b0;
    hit_slot_o = '0;
    for (int s = int'(SLOTS_PER_PAGE) - 1; s >= 0; s--) begin
      if ((RCW'(s) < fill_i) && (row_q[s] == cmp_key_i)) begin
        hit_o      = 1'b1;
        hit_slot_o = SIW'(s);
      end
    end
  end

endmodule

[rtl/first_fit_record_page_store_unit.sv]
// first_fit_record_page_store_unit: top level, command sequencer and result register
// instantiates ffrps_page_table and ffrps_key_store; uses ffrps_pkg
//
// channel   direction  handshake                     payload
// command   in         start && !busy                kind_i, record_bytes_i, key_i
// result    out        result_valid_o (one cycle)    page_index_o, slot_index_o,
//                                                    page_count_o, record_count_o,
//                                                    result_code_o, last_o
// config    in         cfg_we_i                      cfg_wdata_i (page size)
//
// a sequencer walks the pages, reading each page's table entry in ST_READ, then evaluating it in ST_EVAL
// a result leaves the block the cycle after it is decided and cannot be held off
// busy stays high until the last result of a transaction is in the result register
// reset clears the page count and record counters; page size returns to 4096
module first_fit_record_page_store_unit #(
  parameter int unsigned MAX_PAGES      = 16,
  parameter int unsigned SLOTS_PER_PAGE = 32,
  parameter int unsigned KEY_BITS       = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind_i,
  input  logic [15:0] record_bytes_i,
  input  logic [31:0] key_i,
  // page size register
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  // result channel
  output logic        result_valid_o,
  output logic [4:0]  page_index_o,
  output logic [5:0]  slot_index_o,
  output logic [4:0]  page_count_o,
  output logic [5:0]  record_count_o,
  output logic [1:0]  result_code_o,
  output logic        last_o
);

  localparam int unsigned PIW  = MAX_PAGES > 1 ? $clog2(MAX_PAGES) : 1;
  localparam int unsigned PCW  = $clog2(MAX_PAGES + 1);
  localparam int unsigned SIW  = SLOTS_PER_PAGE > 1 ? $clog2(SLOTS_PER_PAGE) : 1;
  localparam int unsigned RCW  = $clog2(SLOTS_PER_PAGE + 1);
  localparam int unsigned FS_W = ffrps_pkg::FS_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_NEW
  } state_e;

  state_e              state_q;
  ffrps_pkg::kind_e    kind_q;
  logic [15:0]         page_size_q;
  logic [PCW-1:0]      pages_used_q;
  logic [PIW-1:0]      page_q;
  logic signed [FS_W-1:0] need_q;
  logic [KEY_BITS-1:0] key_q;

  // result register
  logic                res_valid_q;
  logic [4:0]          res_page_q;
  logic [5:0]          res_slot_q;
  logic [4:0]          res_pcount_q;
  logic [5:0]          res_rcount_q;
  ffrps_pkg::res_e     res_code_q;
  logic                res_last_q;

  // table read data for page_q
  logic signed [FS_W-1:0] rd_free;
  logic [RCW-1:0]         rd_count;
  logic                   key_hit;
  logic [SIW-1:0]         key_hit_slot;

  // write ports
  logic                   pt_we;
  logic [PIW-1:0]         pt_wr_addr;
  logic signed [FS_W-1:0] pt_wr_free;
  logic [RCW-1:0]         pt_wr_count;
  logic                   ks_we;
  logic [SIW-1:0]         ks_wr_slot;

  logic [63:0]            key_wide;
  logic [KEY_BITS-1:0]    key_in;
  logic signed [FS_W-1:0] need_in;
  logic                   accept;
  logic                   fits;
  logic                   last_page;
  logic                   table_full;
  logic [PIW-1:0]         new_page;
  logic signed [FS_W-1:0] fresh_free;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  // keys live in their low KEY_BITS bits
  assign key_wide = {32'd0, key_i};
  assign key_in   = key_wide[KEY_BITS-1:0];
  assign need_in  = FS_W'({2'b00, record_bytes_i}) + FS_W'(ffrps_pkg::SLOT_OVERHEAD);

  // shared compare unit: first-fit test of the page just read
  assign fits       = (rd_count < RCW'(SLOTS_PER_PAGE)) && (rd_free >= need_q);
  assign last_page  = ((PCW'(page_q) + PCW'(1)) == pages_used_q);
  assign table_full = (pages_used_q == PCW'(MAX_PAGES));
  assign new_page   = PIW'(pages_used_q);
  // space of a freshly opened page once the record is in
  assign fresh_free = FS_W'({2'b00, page_size_q}) - FS_W'(ffrps_pkg::HEADER_BYTES) - need_q;

  // table writes happen only when an insert places its record
  always_comb begin
    pt_we       = 1'b0;
    pt_wr_addr  = page_q;
    pt_wr_free  = rd_free - need_q;
    pt_wr_count = rd_count + RCW'(1);
    ks_we       = 1'b0;
    ks_wr_slot  = SIW'(rd_count);
    unique case (state_q)
      ST_EVAL: begin
        if (kind_q == ffrps_pkg::KIND_INSERT && fits) begin
          pt_we = 1'b1;
          ks_we = 1'b1;
        end
      end
      ST_NEW: begin
        pt_wr_addr  = new_page;
        pt_wr_free  = fresh_free;
        pt_wr_count = RCW'(1);
        ks_wr_slot  = '0;
        if (!table_full) begin
          pt_we = 1'b1;
          ks_we = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  ffrps_page_table #(
    .MAX_PAGES      (MAX_PAGES),
    .SLOTS_PER_PAGE (SLOTS_PER_PAGE)
  ) u_page_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_addr_i  (page_q),
    .we_i       (pt_we),
    .wr_addr_i  (pt_wr_addr),
    .wr_free_i  (pt_wr_free),
    .wr_count_i (pt_wr_count),
    .rd_free_o  (rd_free),
    .rd_count_o (rd_count)
  );

  ffrps_key_store #(
    .MAX_PAGES      (MAX_PAGES),
    .SLOTS_PER_PAGE (SLOTS_PER_PAGE),
    .KEY_BITS       (KEY_BITS)
  ) u_key_store (
    .clk_i      (clk_i),
    .rd_page_i  (page_q),
    .we_i       (ks_we),
    .wr_page_i  (pt_wr_addr),
    .wr_slot_i  (ks_wr_slot),
    .wr_key_i   (key_q),
    .cmp_key_i  (key_q),
    .fill_i     (rd_count),
    .hit_o      (key_hit),
    .hit_slot_o (key_hit_slot)
  );

  // sequencer, page size register and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      kind_q       <= ffrps_pkg::KIND_INSERT;
      page_size_q  <= ffrps_pkg::PAGE_SIZE_RST;
      pages_used_q <= '0;
      page_q       <= '0;
      need_q       <= '0;
      key_q        <= '0;
      res_valid_q  <= 1'b0;
      res_page_q   <= '0;
      res_slot_q   <= '0;
      res_pcount_q <= '0;
      res_rcount_q <= '0;
      res_code_q   <= ffrps_pkg::RES_OK;
      res_last_q   <= 1'b0;
    end else begin
      res_valid_q  <= 1'b0;
      res_pcount_q <= '0;
      res_rcount_q <= '0;
      res_code_q   <= ffrps_pkg::RES_OK;
      res_last_q   <= 1'b1;
      if (cfg_we_i) begin
        page_size_q <= cfg_wdata_i;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            need_q <= need_in;
            key_q  <= key_in;
            page_q <= '0;
            unique case (kind_i)
              ffrps_pkg::KIND_INSERT: begin
                kind_q  <= ffrps_pkg::KIND_INSERT;
                state_q <= (pages_used_q == '0) ? ST_NEW : ST_READ;
              end
              ffrps_pkg::KIND_SEARCH: begin
                kind_q <= ffrps_pkg::KIND_SEARCH;
                if (pages_used_q == '0) begin
                  res_valid_q <= 1'b1;
                  res_page_q  <= ffrps_pkg::PAGE_NONE;
                  res_slot_q  <= ffrps_pkg::SLOT_NONE;
                  res_code_q  <= ffrps_pkg::RES_NOT_FOUND;
                end else begin
                  state_q <= ST_READ;
                end
              end
              ffrps_pkg::KIND_STATUS: begin
                // header carries the page count
                kind_q       <= ffrps_pkg::KIND_STATUS;
                res_valid_q  <= 1'b1;
                res_page_q   <= '0;
                res_slot_q   <= '0;
                res_pcount_q <= 5'(pages_used_q);
                res_last_q   <= (pages_used_q == '0);
                if (pages_used_q != '0) begin
                  state_q <= ST_READ;
                end
              end
              default: begin
                // unused kind code: dropped without a result
              end
            endcase
          end
        end
        ST_READ: begin
          state_q <= ST_EVAL;
        end
        ST_EVAL: begin
          unique case (kind_q)
            ffrps_pkg::KIND_INSERT: begin
              if (fits) begin
                res_valid_q <= 1'b1;
                res_page_q  <= 5'(page_q);
                res_slot_q  <= 6'(rd_count);
                state_q     <= ST_IDLE;
              end else if (last_page) begin
                state_q <= ST_NEW;
              end else begin
                page_q  <= page_q + PIW'(1);
                state_q <= ST_READ;
              end
            end
            ffrps_pkg::KIND_SEARCH: begin
              if (key_hit) begin
                res_valid_q <= 1'b1;
                res_page_q  <= 5'(page_q);
                res_slot_q  <= 6'(key_hit_slot);
                state_q     <= ST_IDLE;
              end else if (last_page) begin
                res_valid_q <= 1'b1;
                res_page_q  <= ffrps_pkg::PAGE_NONE;
                res_slot_q  <= ffrps_pkg::SLOT_NONE;
                res_code_q  <= ffrps_pkg::RES_NOT_FOUND;
                state_q     <= ST_IDLE;
              end else begin
                page_q  <= page_q + PIW'(1);
                state_q <= ST_READ;
              end
            end
            default: begin
              // status item for this page
              res_valid_q  <= 1'b1;
              res_page_q   <= 5'(page_q);
              res_slot_q   <= '0;
              res_rcount_q <= 6'(rd_count);
              res_last_q   <= last_page;
              if (last_page) begin
                state_q <= ST_IDLE;
              end else begin
                page_q  <= page_q + PIW'(1);
                state_q <= ST_READ;
              end
            end
          endcase
        end
        ST_NEW: begin
          res_valid_q <= 1'b1;
          state_q     <= ST_IDLE;
          if (table_full) begin
            res_page_q <= ffrps_pkg::PAGE_NONE;
            res_slot_q <= ffrps_pkg::SLOT_NONE;
            res_code_q <= ffrps_pkg::RES_FULL;
          end else begin
            // new page opened, record in slot zero
            res_page_q   <= 5'(new_page);
            res_slot_q   <= '0;
            pages_used_q <= pages_used_q + PCW'(1);
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign result_valid_o = res_valid_q;
  assign page_index_o   = res_page_q;
  assign slot_index_o   = res_slot_q;
  assign page_count_o   = res_pcount_q;
  assign record_count_o = res_rcount_q;
  assign result_code_o  = res_code_q;
  assign last_o         = res_last_q;

endmodule
